>>> src/bmm_pkg.sv
package bmm_pkg;

  localparam int SEGMENT_BITS_DEFAULT = 8;

  localparam logic [7:0] CTL_REG_LOW   = 8'h3C;
  localparam logic [7:0] SEG_REG_LOW   = 8'hFC;
  localparam logic [7:0] SEG_READ_BITS = 8'hC0;
  localparam logic [7:0] CTL_UNUSED    = 8'h10;

  localparam int CTL_MEM_REGS_BIT = 7;
  localparam int CTL_SOUND_BIT    = 6;
  localparam int CTL_PORT_OFF_BIT = 5;
  localparam int CTL_WINDOW_BIT   = 3;

  localparam logic [1:0] PAGE_LOW_WINDOW  = 2'd1;
  localparam logic [1:0] PAGE_HIGH_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    ACT_MEM_READ  = 2'd0,
    ACT_MEM_WRITE = 2'd1,
    ACT_IO_READ   = 2'd2,
    ACT_IO_WRITE  = 2'd3
  } action_t;

  typedef struct packed {
    logic       ctl_we;
    logic [7:0] ctl_wdata;
    logic       seg_we;
    logic [1:0] seg_idx;
    logic [7:0] seg_wdata;
  } reg_wr_t;

  typedef struct packed {
    logic        read_hit;
    logic [7:0]  read_data;
    logic        mem_forward;
    logic        mem_write;
    logic [7:0]  segment;
    logic [13:0] offset;
    logic        sound_write;
    logic [7:0]  sound_data;
  } result_t;

endpackage

>>> src/bmm_regs.sv
module bmm_regs
  import bmm_pkg::*;
#(
  parameter int SEGMENT_BITS = SEGMENT_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  reg_wr_t                         wr,
  output logic [7:0]                      control,
  output logic [3:0][SEGMENT_BITS-1:0]    segs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      control <= '0;
      for (int p = 0; p < 4; p++) begin
        segs[p] <= SEGMENT_BITS'(3 - p);
      end
    end else begin
      if (wr.ctl_we) begin
        control <= wr.ctl_wdata & ~CTL_UNUSED;
      end
      if (wr.seg_we) begin
        segs[wr.seg_idx] <= wr.seg_wdata[SEGMENT_BITS-1:0];
      end
    end
  end

endmodule

>>> src/bmm_decode.sv
module bmm_decode
  import bmm_pkg::*;
#(
  parameter int SEGMENT_BITS = SEGMENT_BITS_DEFAULT
) (
  input  logic [1:0]                      action,
  input  logic [15:0]                     address,
  input  logic [7:0]                      data,
  input  logic [7:0]                      control,
  input  logic [3:0][SEGMENT_BITS-1:0]    segs,
  output result_t                         res,
  output reg_wr_t                         wr
);

  localparam logic [7:0] SegMask = 8'((1 << SEGMENT_BITS) - 1);

  logic [7:0] low;
  logic [1:0] page;
  logic       in_window;
  logic       is_ctl_reg;
  logic       is_seg_reg;
  logic [7:0] seg_low;
  logic [7:0] seg_page;
  logic [7:0] ctl_mem_wdata;

  always_comb begin
    low      = address[7:0];
    page     = address[15:14];
    seg_low  = 8'(segs[low[1:0]]);
    seg_page = 8'(segs[page]);
    is_ctl_reg = (low == CTL_REG_LOW);
    is_seg_reg = ((low & SEG_REG_LOW) == SEG_REG_LOW);

    if (!control[CTL_MEM_REGS_BIT]) begin
      in_window = 1'b0;
    end else if (control[CTL_PORT_OFF_BIT]) begin
      in_window = control[CTL_WINDOW_BIT] ? (page == PAGE_LOW_WINDOW)
                                          : (page == PAGE_HIGH_WINDOW);
    end else begin
      in_window = (page == PAGE_LOW_WINDOW) || (page == PAGE_HIGH_WINDOW);
    end

    ctl_mem_wdata = data;
    if (data[CTL_PORT_OFF_BIT]) begin
      ctl_mem_wdata[CTL_MEM_REGS_BIT] = 1'b1;
    end

    res = '0;
    wr  = '0;
    wr.seg_idx   = low[1:0];
    wr.seg_wdata = data;

    unique case (action_t'(action))
      ACT_MEM_READ, ACT_MEM_WRITE: begin
        if (in_window && is_ctl_reg) begin
          if (action_t'(action) == ACT_MEM_READ) begin
            res.read_hit  = 1'b1;
            res.read_data = control;
          end else begin
            wr.ctl_we    = 1'b1;
            wr.ctl_wdata = ctl_mem_wdata;
          end
        end else if (in_window && is_seg_reg) begin
          if (action_t'(action) == ACT_MEM_READ) begin
            res.read_hit  = 1'b1;
            res.read_data = SEG_READ_BITS | seg_low;
          end else begin
            wr.seg_we = 1'b1;
          end
        end else if (!(action_t'(action) == ACT_MEM_WRITE && control[page])) begin
          res.mem_forward = 1'b1;
          res.mem_write   = (action_t'(action) == ACT_MEM_WRITE);
          res.segment     = seg_page;
          res.offset      = address[13:0];
        end
      end
      ACT_IO_READ: begin
        res.read_hit  = 1'b1;
        res.read_data = control[CTL_PORT_OFF_BIT] ? 8'hFF : (seg_low | ~SegMask);
      end
      ACT_IO_WRITE: begin
        if (is_seg_reg) begin
          wr.seg_we = !control[CTL_PORT_OFF_BIT];
        end else if (low[0]) begin
          if (control[CTL_SOUND_BIT]) begin
            res.sound_write = 1'b1;
            res.sound_data  = data;
          end
        end else begin
          wr.ctl_we    = 1'b1;
          wr.ctl_wdata = {data[CTL_MEM_REGS_BIT], control[CTL_MEM_REGS_BIT-1:0]};
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> src/banked_memory_mapper_with_control_core.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    action, address, data
// out      output     out_valid / out_ready  read_hit, read_data, mem_forward, mem_write,
//                                            segment, offset, sound_write, sound_data
//
// Every input transaction gives exactly one output, through the input and result registers.
// One transaction per cycle is sustained unless the output stalls: decode between the input
// and result registers is the only stage; the next transaction sees register updates.
// Reset clears the control byte and loads page segments 3, 2, 1, 0.
// A stalled output holds the result register; the input register still fills behind it.
module banked_memory_mapper_with_control_core
  import bmm_pkg::*;
#(
  parameter int SEGMENT_BITS = SEGMENT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        read_hit,
  output logic [7:0]  read_data,
  output logic        mem_forward,
  output logic        mem_write,
  output logic [7:0]  segment,
  output logic [13:0] offset,
  output logic        sound_write,
  output logic [7:0]  sound_data
);

  logic                          in_full;
  logic [1:0]                    action_q;
  logic [15:0]                   address_q;
  logic [7:0]                    data_q;
  logic                          advance;
  logic [7:0]                    control;
  logic [3:0][SEGMENT_BITS-1:0]  segs;
  result_t                       res;
  result_t                       res_q;
  reg_wr_t                       dec_wr;
  reg_wr_t                       wr;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_comb begin
    wr        = dec_wr;
    wr.ctl_we = dec_wr.ctl_we && advance;
    wr.seg_we = dec_wr.seg_we && advance;
  end

  bmm_decode #(
    .SEGMENT_BITS(SEGMENT_BITS)
  ) u_decode (
    .action (action_q),
    .address(address_q),
    .data   (data_q),
    .control(control),
    .segs   (segs),
    .res    (res),
    .wr     (dec_wr)
  );

  bmm_regs #(
    .SEGMENT_BITS(SEGMENT_BITS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .control(control),
    .segs   (segs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_q  <= action;
      address_q <= address;
      data_q    <= data;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign read_hit    = res_q.read_hit;
  assign read_data   = res_q.read_data;
  assign mem_forward = res_q.mem_forward;
  assign mem_write   = res_q.mem_write;
  assign segment     = res_q.segment;
  assign offset      = res_q.offset;
  assign sound_write = res_q.sound_write;
  assign sound_data  = res_q.sound_data;

endmodule
